// File: rtl/core/swrb_pkg.sv
// shared types and codes for the sequence window ring buffer
`timescale 1ns / 1ps

package swrb_pkg;

	// default ring size, a power of two
	localparam int unsigned CAPACITY_DEF = 32;

	// operation codes
	localparam logic [1:0] MODE_SLOT = 2'd0;
	localparam logic [1:0] MODE_ENQ  = 2'd1;
	localparam logic [1:0] MODE_DEQ  = 2'd2;
	localparam logic [1:0] MODE_READ = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_WINDOW = 3'd1;
	localparam logic [2:0] ST_EMPTY  = 3'd2;
	localparam logic [2:0] ST_FULL   = 3'd3;
	localparam logic [2:0] ST_RANGE  = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_LOOKUP,
		S_EXTEND,
		S_DONE
	} seq_state_t;

	// request item
	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] seq_number;
		logic [4:0] slot_position;
	} req_item_t;

	// result item
	typedef struct packed {
		logic [4:0] slot_index;
		logic [7:0] slot_seq;
		logic [2:0] status;
		logic [5:0] used_count;
	} rsp_item_t;

endpackage

// File: rtl/core/swrb_tag_ram.sv
// tag memory: one write port, one registered read port
`timescale 1ns / 1ps

module swrb_tag_ram #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/swrb_seq.sv
// sequencer: head and tail pointers, tag memory access and result build
`timescale 1ns / 1ps

module swrb_seq #(
	parameter int unsigned CAPACITY = swrb_pkg::CAPACITY_DEF,
	parameter int unsigned PW       = 6,
	parameter int unsigned SW       = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  swrb_pkg::req_item_t req,
	output logic               res_valid,
	input  logic               res_take,
	output swrb_pkg::rsp_item_t res,
	output logic               mem_we,
	output logic [SW-1:0]      mem_waddr,
	output logic [7:0]         mem_wdata,
	output logic [SW-1:0]      mem_raddr,
	input  logic [7:0]         mem_rdata
);

	import swrb_pkg::*;

	localparam int unsigned WW = PW + 8;
	localparam logic [PW-1:0] SLOT_MASK = PW'(CAPACITY - 1);
	localparam logic [WW-1:0] CAP_W     = WW'(CAPACITY);

	seq_state_t state_q, state_nxt;

	logic [PW-1:0] head_q, tail_q;
	logic [1:0]    mode_q;
	logic [7:0]    seq_q;
	logic          opened_q;
	logic [7:0]    first_q;
	logic [7:0]    offset_q;
	logic [PW-1:0] res_slot_q;
	logic [7:0]    res_tag_q;
	logic [2:0]    res_status_q;

	logic [PW-1:0] occ, head_slot, tail_slot, pos_slot, target_slot;
	logic [WW-1:0] occ_w, offset_w, target_w;
	logic          empty, full, accept;
	logic [7:0]    base_tag, offset;
	logic          head_inc, tail_inc;
	logic [PW-1:0] acc_slot;
	logic [7:0]    acc_tag;
	logic [2:0]    acc_status;

	// occupancy and slot positions
	assign occ       = tail_q - head_q;
	assign occ_w     = WW'(occ);
	assign empty     = (occ == '0);
	assign full      = (occ_w >= CAP_W);
	assign head_slot = head_q & SLOT_MASK;
	assign tail_slot = tail_q & SLOT_MASK;
	assign pos_slot  = PW'(req.slot_position) & SLOT_MASK;
	assign accept    = (state_q == S_IDLE) && req_valid;

	// window offset from the head tag, valid in the read state
	assign base_tag    = opened_q ? seq_q : mem_rdata;
	assign offset      = seq_q - base_tag;
	assign offset_w    = WW'(offset);
	assign target_w    = WW'(head_slot) + offset_w;
	assign target_slot = PW'(target_w) & SLOT_MASK;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (req.mode == MODE_ENQ || (req.mode == MODE_DEQ && empty)) begin
						state_nxt = S_DONE;
					end else begin
						state_nxt = S_READ;
					end
				end
			end
			S_READ: begin
				if (mode_q != MODE_SLOT || offset_w >= CAP_W) begin
					state_nxt = S_DONE;
				end else if (offset_w < occ_w) begin
					state_nxt = S_LOOKUP;
				end else begin
					state_nxt = S_EXTEND;
				end
			end
			S_LOOKUP: state_nxt = S_DONE;
			S_EXTEND: begin
				if (WW'(offset_q) == occ_w) begin
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				if (res_take) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// memory and pointer controls
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = SW'(tail_slot);
		mem_wdata = seq_q;
		mem_raddr = SW'(head_slot);
		head_inc  = 1'b0;
		tail_inc  = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				mem_wdata = req.seq_number;
				if (req.mode == MODE_READ) begin
					mem_raddr = SW'(pos_slot);
				end
				if (accept) begin
					case (req.mode)
						MODE_SLOT: begin
							mem_we   = empty;
							tail_inc = empty;
						end
						MODE_ENQ: begin
							mem_we   = !full;
							tail_inc = !full;
						end
						MODE_DEQ: head_inc = !empty;
						default: ;
					endcase
				end
			end
			S_READ: mem_raddr = SW'(target_slot);
			S_EXTEND: begin
				mem_we    = 1'b1;
				mem_wdata = first_q + 8'(occ);
				tail_inc  = 1'b1;
			end
			S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	// result fields decided at request transfer
	always_comb begin
		acc_slot   = '0;
		acc_tag    = 8'd0;
		acc_status = ST_OK;
		case (req.mode)
			MODE_ENQ: begin
				if (full) begin
					acc_status = ST_FULL;
				end else begin
					acc_slot = tail_slot;
					acc_tag  = req.seq_number;
				end
			end
			MODE_DEQ: begin
				if (empty) begin
					acc_status = ST_EMPTY;
				end else begin
					acc_slot = head_slot;
				end
			end
			MODE_READ: begin
				acc_slot = pos_slot;
				if (pos_slot >= occ) begin
					acc_status = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (head_inc) begin
				head_q <= head_q + PW'(1);
			end
			if (tail_inc) begin
				tail_q <= tail_q + PW'(1);
			end
		end
	end

	// operation context and result fields
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				mode_q       <= req.mode;
				seq_q        <= req.seq_number;
				opened_q     <= empty;
				res_tag_q    <= acc_tag;
				res_slot_q   <= acc_slot;
				res_status_q <= acc_status;
			end
			S_READ: begin
				first_q  <= base_tag;
				offset_q <= offset;
				case (mode_q)
					MODE_SLOT: begin
						if (offset_w >= CAP_W) begin
							res_status_q <= ST_WINDOW;
						end else begin
							res_slot_q <= target_slot;
							res_tag_q  <= seq_q;
						end
					end
					MODE_DEQ: res_tag_q <= mem_rdata;
					MODE_READ: begin
						if (res_status_q == ST_OK) begin
							res_tag_q <= mem_rdata;
						end
					end
					default: ;
				endcase
			end
			S_LOOKUP: res_tag_q <= mem_rdata;
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE);

	// result handed to the output register
	always_comb begin
		res.slot_index = 5'(res_slot_q);
		res.slot_seq   = res_tag_q;
		res.status     = res_status_q;
		res.used_count = 6'(occ);
	end

	// ring never holds more than its capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_w <= CAP_W)
		else $error("ring occupancy beyond capacity");

	// extension only appends up to the requested offset
	a_extend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXTEND |-> occ_w <= WW'(offset_q))
		else $error("extension overran the requested offset");

	// pointers move only on an accepted item or during extension
	a_ptr_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ || state_q == S_LOOKUP || state_q == S_DONE)
		|=> $stable(head_q) && $stable(tail_q))
		else $error("pointer moved outside an update step");

endmodule

// File: rtl/core/sequence_window_ring_buffer.sv
// Sequence window ring buffer. Enqueue, full enqueue and empty dequeue go from idle straight to
// done; dequeue, read, range and window faults pass through the read state; a slot-for-sequence
// request passes through read and lookup with no extension, or through read and extend with one,
// appending slots one tag write per cycle through the single tag memory write port. Each result
// then passes through the output register. One request in work at a time.
// Reset clears head and tail pointers and the sequencer; the tag memory is not cleared.
`timescale 1ns / 1ps

module sequence_window_ring_buffer #(
	parameter int unsigned CAPACITY = swrb_pkg::CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  swrb_pkg::req_item_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output swrb_pkg::rsp_item_t rsp
);

	import swrb_pkg::*;

	localparam int unsigned PW = $clog2(2 * CAPACITY);
	localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	logic          res_valid, res_take;
	rsp_item_t     res;
	logic          mem_we;
	logic [SW-1:0] mem_waddr, mem_raddr;
	logic [7:0]    mem_wdata, mem_rdata;
	logic          out_valid_q;
	rsp_item_t     out_q;

	swrb_seq #(
		.CAPACITY (CAPACITY),
		.PW       (PW),
		.SW       (SW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	swrb_tag_ram #(
		.DEPTH (CAPACITY),
		.AW    (SW)
	) u_tag_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register takes a result when empty or being drained
	assign res_take = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// reported occupancy stays within the ring
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> 32'(rsp.used_count) <= CAPACITY)
		else $error("reported occupancy beyond capacity");

	// faulted window, full and empty results carry no slot
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_WINDOW || rsp.status == ST_FULL ||
		rsp.status == ST_EMPTY) |-> rsp.slot_index == '0 && rsp.slot_seq == '0)
		else $error("faulted result carries a slot");

	// an out-of-range read really lies at or beyond the occupancy
	a_range_check: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_RANGE |->
		rsp.used_count <= 6'(rsp.slot_index) && rsp.slot_seq == '0)
		else $error("range fault on an occupied slot");

endmodule
